// File: rtl/dmxf_pkg.sv
// Shared types, codes and reset values of the DMX / UART symbol framer.
`default_nettype none
package dmxf_pkg;

    // Register indexes on the configuration port.
    localparam logic [7:0] REG_BIT_TICKS   = 8'd0;
    localparam logic [7:0] REG_BREAK_TICKS = 8'd1;
    localparam logic [7:0] REG_MAB_TICKS   = 8'd2;
    localparam logic [7:0] REG_DMX_MODE    = 8'd3;

    // Register reset values.
    localparam logic [15:0] BIT_TICKS_RST   = 16'd40;
    localparam logic [16:0] BREAK_TICKS_RST = 17'd920;
    localparam logic [16:0] MAB_TICKS_RST   = 17'd120;
    localparam logic        DMX_MODE_RST    = 1'b1;

    // Symbol kinds as they appear on the result channel.
    localparam logic [2:0] KIND_BREAK = 3'd0;
    localparam logic [2:0] KIND_MAB   = 3'd1;
    localparam logic [2:0] KIND_START = 3'd2;
    localparam logic [2:0] KIND_DATA  = 3'd3;
    localparam logic [2:0] KIND_STOP  = 3'd4;

    // Sequencer steps of the back end, one symbol per step.
    localparam logic [2:0] STEP_BREAK = 3'd0;
    localparam logic [2:0] STEP_MAB   = 3'd1;
    localparam logic [2:0] STEP_START = 3'd2;
    localparam logic [2:0] STEP_DATA0 = 3'd3;
    localparam logic [2:0] STEP_DATA3 = 3'd6;
    localparam logic [2:0] STEP_STOP  = 3'd7;

    // Default depth of the queue between front and back end.
    localparam int QUEUE_DEPTH_DEF = 4;

    // One classified byte waiting for the back end.
    typedef struct packed {
        logic       with_break;
        logic       frame_end;
        logic [7:0] data_byte;
    } byte_cmd_t;

    // Symbol timing registers handed to the back end.
    typedef struct packed {
        logic [15:0] bit_ticks;
        logic [16:0] break_ticks;
        logic [16:0] mab_ticks;
    } timing_t;

    // Queue status toward the producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage
`default_nettype wire

// File: rtl/dmxf_front.sv
// Front end: accepts bytes, tracks frame position and decides on break and MAB.
`default_nettype none
module dmxf_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [7:0]            s_tdata,
    input  wire                   s_tlast,
    input  wire                   dmx_mode,
    input  dmxf_pkg::queue_stat_t q_stat,
    output logic                  q_push,
    output dmxf_pkg::byte_cmd_t   q_cmd
);

    logic frame_open_reg;
    logic frame_open_next;

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

    // A byte opening a frame in DMX mode is preceded by break and MAB.
    always_comb begin
        q_cmd.data_byte  = s_tdata;
        q_cmd.frame_end  = s_tlast;
        q_cmd.with_break = !frame_open_reg && dmx_mode;
    end

    always_comb begin
        frame_open_next = frame_open_reg;
        if (q_push) begin
            frame_open_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
        end else begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dmxf_queue.sv
// Small FIFO of classified bytes between front end and back end.
`default_nettype none
module dmxf_queue #(
    parameter int DEPTH = dmxf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  dmxf_pkg::byte_cmd_t   push_cmd,
    input  wire                   pop,
    output dmxf_pkg::byte_cmd_t   head_cmd,
    output dmxf_pkg::queue_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dmxf_pkg::byte_cmd_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dmxf_back.sv
// Back end: steps through the symbols of each queued byte, one per cycle while the result port is not stalled.
`default_nettype none
module dmxf_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  dmxf_pkg::timing_t     timing,
    input  dmxf_pkg::byte_cmd_t   head_cmd,
    input  dmxf_pkg::queue_stat_t q_stat,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tlast,
    output logic [3:0]            m_tuser
);

    logic        active_reg, active_next;
    logic [2:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic        lvl0_reg, lvl1_reg;
    logic [16:0] ticks_reg;
    logic [2:0]  kind_reg;
    logic        last_reg, done_reg;

    logic        load;
    logic        emit;
    logic [2:0]  cur_step;
    logic [2:0]  pair_idx;
    logic [1:0]  pair;
    logic        lvl0_d, lvl1_d;
    logic [16:0] ticks_d;
    logic [2:0]  kind_d;
    logic        last_d, done_d;

    // The output register takes a new symbol when empty or being drained.
    assign load = !valid_reg || m_tready;
    assign emit = load && !q_stat.empty;

    // A fresh byte starts at the break or, without one, at its start bit.
    assign cur_step = active_reg ? step_reg
                    : (head_cmd.with_break ? dmxf_pkg::STEP_BREAK
                                           : dmxf_pkg::STEP_START);
    assign q_pop = emit && (cur_step == dmxf_pkg::STEP_STOP);

    assign pair_idx = cur_step - dmxf_pkg::STEP_DATA0;
    assign pair     = head_cmd.data_byte[{pair_idx[1:0], 1'b0} +: 2];

    always_comb begin
        lvl0_d  = 1'b0;
        lvl1_d  = 1'b0;
        ticks_d = {1'b0, timing.bit_ticks};
        kind_d  = dmxf_pkg::KIND_START;
        last_d  = 1'b0;
        done_d  = 1'b0;
        unique case (cur_step)
            dmxf_pkg::STEP_BREAK: begin
                ticks_d = timing.break_ticks;
                kind_d  = dmxf_pkg::KIND_BREAK;
            end
            dmxf_pkg::STEP_MAB: begin
                lvl0_d  = 1'b1;
                lvl1_d  = 1'b1;
                ticks_d = timing.mab_ticks;
                kind_d  = dmxf_pkg::KIND_MAB;
            end
            dmxf_pkg::STEP_START: begin
                ticks_d = {1'b0, timing.bit_ticks};
                kind_d  = dmxf_pkg::KIND_START;
            end
            dmxf_pkg::STEP_STOP: begin
                lvl0_d  = 1'b1;
                lvl1_d  = 1'b1;
                ticks_d = {timing.bit_ticks, 1'b0};
                kind_d  = dmxf_pkg::KIND_STOP;
                last_d  = 1'b1;
                done_d  = head_cmd.frame_end;
            end
            default: begin
                // Data pairs: lower bit of the pair goes in the first half.
                lvl0_d  = pair[0];
                lvl1_d  = pair[1];
                ticks_d = {timing.bit_ticks, 1'b0};
                kind_d  = dmxf_pkg::KIND_DATA;
            end
        endcase
    end

    always_comb begin
        active_next = active_reg;
        step_next   = step_reg;
        valid_next  = valid_reg;
        if (load) begin
            valid_next = emit;
        end
        if (emit) begin
            if (cur_step == dmxf_pkg::STEP_STOP) begin
                active_next = 1'b0;
            end else begin
                active_next = 1'b1;
                step_next   = cur_step + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            step_reg   <= dmxf_pkg::STEP_BREAK;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            step_reg   <= step_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            lvl0_reg  <= lvl0_d;
            lvl1_reg  <= lvl1_d;
            ticks_reg <= ticks_d;
            kind_reg  <= kind_d;
            last_reg  <= last_d;
            done_reg  <= done_d;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, ticks_reg, lvl1_reg, lvl0_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {done_reg, kind_reg};

endmodule
`default_nettype wire

// File: rtl/dmx_uart_symbol_framer.sv
// Top level of the DMX512 / UART 8N2 symbol framer with its configuration registers.
`default_nettype none
// The framer turns a stream of bytes into pulse symbols for a line driver.
// Each symbol carries a first-half level, a second-half level and a total
// duration in ticks. Every byte gives a low start bit, four data-pair symbols
// (least significant pair first, lower bit in the first half) and a high stop
// symbol two bits long; a byte that opens a frame while DMX mode is on is led
// by a low break and a high mark-after-break. The stop symbol raises tlast,
// and on the final byte of a frame (input tlast) it also sets frame_done.
// Throughput is one symbol per clock on the result side while m_tready is
// not held low and the queue is not empty, set by the back-end sequencer
// that produces one symbol per cycle. The front end accepts bytes into a
// queue of QUEUE_DEPTH entries, so input requests are taken while the
// back end is still busy with earlier bytes, as long as the queue is not
// full; a byte accepted into an empty block is stored in a queue entry and
// its first symbol then in the back-end output register. Configuration registers
// should be written only while no byte is in flight; the port is always ready.
module dmx_uart_symbol_framer #(
    parameter int QUEUE_DEPTH = dmxf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Input byte channel.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tlast,   // frame_end
    // Symbol result channel.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [0] first_level, [1] second_level,
                                   // [18:2] symbol_ticks, [23:19] zero
    output logic        m_tlast,   // run_last
    output logic [3:0]  m_tuser,   // [2:0] symbol_kind, [3] frame_done
    // Configuration write channel.
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_index,
    input  wire  [31:0] cfg_data
);

    logic [15:0] bit_ticks_reg;
    logic [16:0] break_ticks_reg;
    logic [16:0] mab_ticks_reg;
    logic        dmx_mode_reg;
    logic        cfg_wr;

    dmxf_pkg::timing_t     timing;
    dmxf_pkg::byte_cmd_t   push_cmd;
    dmxf_pkg::byte_cmd_t   head_cmd;
    dmxf_pkg::queue_stat_t q_stat;
    logic                  q_push;
    logic                  q_pop;

    // Register writes complete in the cycle they are presented. Indexes
    // beyond the register list are accepted and ignored; excess data bits
    // above a register's width are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg   <= dmxf_pkg::BIT_TICKS_RST;
            break_ticks_reg <= dmxf_pkg::BREAK_TICKS_RST;
            mab_ticks_reg   <= dmxf_pkg::MAB_TICKS_RST;
            dmx_mode_reg    <= dmxf_pkg::DMX_MODE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                dmxf_pkg::REG_BIT_TICKS:   bit_ticks_reg   <= cfg_data[15:0];
                dmxf_pkg::REG_BREAK_TICKS: break_ticks_reg <= cfg_data[16:0];
                dmxf_pkg::REG_MAB_TICKS:   mab_ticks_reg   <= cfg_data[16:0];
                dmxf_pkg::REG_DMX_MODE:    dmx_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign timing.bit_ticks   = bit_ticks_reg;
    assign timing.break_ticks = break_ticks_reg;
    assign timing.mab_ticks   = mab_ticks_reg;

    // Front end: accepts bytes and marks those that open a DMX frame.
    dmxf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .dmx_mode (dmx_mode_reg),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Queue decoupling byte acceptance from symbol generation.
    dmxf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // Back end: emits the symbols of the head byte into the output register.
    dmxf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .timing   (timing),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
